>>> hdl/jbhe_pkg.sv
// Shared types, constants and helpers for the baseline Huffman entropy encoder.
// Used by jbhe_datapath, jbhe_ctrl, the top level and the checker.
package jbhe_pkg;

    localparam int NUM_COMPONENTS_DEF = 4;
    localparam int NUM_TABLES_DEF     = 2;
    localparam int BLOCK_COEFS        = 64;
    localparam int DC_SYMBOLS         = 12;
    localparam int AC_SYMBOLS         = 256;
    localparam int MAX_CODE_LEN       = 16;
    localparam int ACC_W              = 24;
    localparam int CNT_W              = 5;

    localparam logic [1:0] KIND_COEF   = 2'd0;
    localparam logic [1:0] KIND_DC_TAB = 2'd1;
    localparam logic [1:0] KIND_AC_TAB = 2'd2;

    localparam logic [1:0] CFG_RESTART_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_DC_TABLE_MAP     = 2'd1;
    localparam logic [1:0] CFG_AC_TABLE_MAP     = 2'd2;
    localparam logic [1:0] CFG_COMPONENT_COUNT  = 2'd3;

    localparam logic [7:0] SYM_ZRL    = 8'hF0;
    localparam logic [7:0] SYM_EOB    = 8'h00;
    localparam logic [6:0] PAD_ONES   = 7'h7F;
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_STUFF = 8'h00;
    localparam logic [7:0] MARKER_RST = 8'hD0;

    typedef struct packed {
        logic capture;
        logic dc_diff;
        logic ac_prep;
        logic zr_inc;
        logic zr_sub16;
        logic zr_clear;
        logic look_dc;
        logic look_zrl;
        logic look_ac;
        logic look_eob;
        logic put_dc;
        logic put_ac;
        logic put_amp;
        logic put_pad;
        logic clear_pend;
        logic drain_byte;
        logic emit_stuff;
        logic emit_ff;
        logic emit_rnum;
        logic rst_apply;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_dc;
        logic       val_zero;
        logic       idx_last;
        logic       restart_due;
        logic       zr_gt15;
        logic       count_ge8;
        logic       byte_ff;
        logic       can_emit;
        logic       held_v;
        logic       out_free;
    } stat_t;

    // magnitude category: index of highest set bit plus one
    function automatic logic [3:0] size_of(input logic [11:0] mag);
        logic [3:0] s;
        s = 4'd0;
        for (int i = 0; i < 12; i++) begin
            if (mag[i]) begin
                s = 4'(i + 1);
            end
        end
        return s;
    endfunction

    // small remainder by repeated subtraction, value below 4
    function automatic logic [1:0] mod_small(input logic [1:0] v, input logic [2:0] m);
        logic [2:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 3; i++) begin
            if (r >= m) begin
                r = r - m;
            end
        end
        return r[1:0];
    endfunction

endpackage

>>> hdl/jpeg_baseline_huffman_encoder_core.sv
// Top level of the baseline Huffman entropy encoder: controller plus datapath.
// Depends on jbhe_pkg, jbhe_ctrl and jbhe_datapath.
//
// Input channel (in_valid/in_stall) takes one word per item: a quantized
// zigzag coefficient (kind 0) or a DC/AC code table entry write (kind 1/2).
// Output channel (out_valid/out_stall) delivers the stream bytes, including
// 0x00 stuffing after 0xFF and RSTn markers; last marks an item's final byte.
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user must do so only while the block is idle; the block does not check it.
// Each code table is a memory with a registered read, one lookup per code symbol.
// in_stall is low only while the controller is idle.
// The item's final byte is held back until the item finishes, then loaded
// into the output register; the next item may be accepted while it waits.
// When the receiver stalls, bytes back up into the hold stage and the
// controller waits; nothing is dropped.
// Reset clears predictors, run count, bit packer, restart counters and
// configuration; code tables stay undefined until written.
module jpeg_baseline_huffman_encoder_core #(
    parameter int NUM_COMPONENTS = jbhe_pkg::NUM_COMPONENTS_DEF,
    parameter int NUM_TABLES     = jbhe_pkg::NUM_TABLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [10:0] coef_value,
    input  logic [5:0]         coef_index,
    input  logic [1:0]         component,
    input  logic               mcu_start,
    input  logic               table_select,
    input  logic [7:0]         table_symbol,
    input  logic [15:0]        table_code,
    input  logic [4:0]         table_length,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               last,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import jbhe_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    jbhe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    jbhe_datapath #(
        .NUM_COMPONENTS (NUM_COMPONENTS),
        .NUM_TABLES     (NUM_TABLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .coef_value   (coef_value),
        .coef_index   (coef_index),
        .component    (component),
        .mcu_start    (mcu_start),
        .table_select (table_select),
        .table_symbol (table_symbol),
        .table_code   (table_code),
        .table_length (table_length),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .last         (last)
    );

endmodule

>>> hdl/jbhe_datapath.sv
// Datapath: item capture, code tables, DC predictors, run counter, bit packer
// and byte emitter with a one-byte hold for the last flag. Uses jbhe_pkg.
module jbhe_datapath #(
    parameter int NUM_COMPONENTS = jbhe_pkg::NUM_COMPONENTS_DEF,
    parameter int NUM_TABLES     = jbhe_pkg::NUM_TABLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  jbhe_pkg::cmd_t      cmd,
    output jbhe_pkg::stat_t     stat,
    input  logic [1:0]          kind,
    input  logic signed [10:0]  coef_value,
    input  logic [5:0]          coef_index,
    input  logic [1:0]          component,
    input  logic                mcu_start,
    input  logic                table_select,
    input  logic [7:0]          table_symbol,
    input  logic [15:0]         table_code,
    input  logic [4:0]          table_length,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                last
);
    import jbhe_pkg::*;

    localparam int CW      = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int DC_DEP  = NUM_TABLES * DC_SYMBOLS;
    localparam int AC_DEP  = NUM_TABLES * AC_SYMBOLS;
    localparam int DA      = $clog2(DC_DEP);
    localparam int AA      = $clog2(AC_DEP);

    logic [20:0] dc_mem [DC_DEP];
    logic [20:0] ac_mem [AC_DEP];
    logic [20:0] dc_rdata_reg;
    logic [20:0] ac_rdata_reg;

    logic [15:0] restart_interval_reg;
    logic [3:0]  dc_map_reg;
    logic [3:0]  ac_map_reg;
    logic [2:0]  comp_count_reg;

    logic [1:0]         kind_reg;
    logic signed [10:0] val_reg;
    logic [5:0]         idx_reg;
    logic [1:0]         comp_reg;
    logic               mstart_reg;

    logic signed [10:0] prev_reg [NUM_COMPONENTS];
    logic [5:0]         zr_reg;
    logic [5:0]         zr_next;
    logic [15:0]        mcus_reg;
    logic [15:0]        mcus_next;
    logic [2:0]         rnum_reg;
    logic [2:0]         rnum_next;

    logic signed [11:0] amp_reg;
    logic [3:0]         size_reg;

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    logic [7:0] held_reg;
    logic       held_v_reg;
    logic       held_v_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    logic [CW-1:0]      comp_sel;
    logic               dt;
    logic               at;
    logic               wt;
    logic signed [11:0] diff;
    logic [11:0]        diff_mag;
    logic [11:0]        val_mag;
    logic [DA-1:0]      dc_addr;
    logic [DA-1:0]      dc_waddr;
    logic [AA-1:0]      ac_addr;
    logic [AA-1:0]      ac_waddr;
    logic [7:0]         ac_sym;
    logic               do_put;
    logic [20:0]        put_entry;
    logic [15:0]        put_code;
    logic [4:0]         put_len;
    logic [16:0]        put_mask;
    logic [11:0]        amp_bits;
    logic [7:0]         drain_val;
    logic               emit_v;
    logic [7:0]         emit_data;
    logic               out_free;

    assign comp_sel = CW'(mod_small(comp_reg, 3'(NUM_COMPONENTS)));
    assign dt = (NUM_TABLES > 1) ? dc_map_reg[comp_sel] : 1'b0;
    assign at = (NUM_TABLES > 1) ? ac_map_reg[comp_sel] : 1'b0;
    assign wt = (NUM_TABLES > 1) ? table_select : 1'b0;

    assign diff     = 12'(val_reg) - 12'(prev_reg[comp_sel]);
    assign diff_mag = diff[11] ? 12'(-diff) : 12'(diff);
    assign val_mag  = val_reg[10] ? 12'(-12'(val_reg)) : 12'(val_reg);

    assign dc_addr  = dt ? DA'(DC_SYMBOLS) + DA'(size_reg) : DA'(size_reg);
    assign dc_waddr = wt ? DA'(DC_SYMBOLS) + DA'(table_symbol[3:0]) : DA'(table_symbol[3:0]);

    always_comb
    begin
        priority if (cmd.look_zrl)
        begin
            ac_sym = SYM_ZRL;
        end
        else if (cmd.look_eob)
        begin
            ac_sym = SYM_EOB;
        end
        else
        begin
            ac_sym = {zr_reg[3:0], size_reg};
        end
    end

    assign ac_addr  = AA'({at, ac_sym});
    assign ac_waddr = AA'({wt, table_symbol});

    // code tables
    always_ff @(posedge clk)
    begin
        if (cmd.capture && kind == KIND_DC_TAB && table_symbol < 8'(DC_SYMBOLS))
        begin
            dc_mem[dc_waddr] <= {table_length, table_code};
        end
        if (cmd.capture && kind == KIND_AC_TAB)
        begin
            ac_mem[ac_waddr] <= {table_length, table_code};
        end
        if (cmd.look_dc)
        begin
            dc_rdata_reg <= dc_mem[dc_addr];
        end
        if (cmd.look_zrl || cmd.look_ac || cmd.look_eob)
        begin
            ac_rdata_reg <= ac_mem[ac_addr];
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_interval_reg <= '0;
            dc_map_reg           <= '0;
            ac_map_reg           <= '0;
            comp_count_reg       <= 3'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RESTART_INTERVAL: restart_interval_reg <= cfg_data;
                CFG_DC_TABLE_MAP:     dc_map_reg <= cfg_data[3:0];
                CFG_AC_TABLE_MAP:     ac_map_reg <= cfg_data[3:0];
                CFG_COMPONENT_COUNT:  comp_count_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // captured item and amplitude
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            val_reg    <= coef_value;
            idx_reg    <= coef_index;
            comp_reg   <= component;
            mstart_reg <= mcu_start;
        end
        if (cmd.dc_diff)
        begin
            amp_reg  <= diff;
            size_reg <= size_of(diff_mag);
        end
        else if (cmd.ac_prep)
        begin
            amp_reg  <= 12'(val_reg);
            size_reg <= size_of(val_mag);
        end
    end

    // predictors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COMPONENTS; c++)
            begin
                prev_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < NUM_COMPONENTS; c++)
            begin
                if (cmd.rst_apply && 3'(c) < comp_count_reg)
                begin
                    prev_reg[c] <= '0;
                end
                else if (cmd.dc_diff && comp_sel == CW'(c))
                begin
                    prev_reg[c] <= val_reg;
                end
            end
        end
    end

    always_comb
    begin
        zr_next   = zr_reg;
        mcus_next = mcus_reg;
        rnum_next = rnum_reg;
        if (cmd.zr_inc && zr_reg != 6'd63)
        begin
            zr_next = zr_reg + 6'd1;
        end
        if (cmd.zr_sub16)
        begin
            zr_next = zr_reg - 6'd16;
        end
        if (cmd.zr_clear || cmd.dc_diff)
        begin
            zr_next = '0;
        end
        if (cmd.rst_apply)
        begin
            mcus_next = '0;
            rnum_next = rnum_reg + 3'd1;
        end
        if (cmd.dc_diff && mstart_reg && restart_interval_reg != '0)
        begin
            mcus_next = mcus_reg + 16'd1;
        end
    end

    // bit packer
    assign amp_bits = amp_reg[11] ? 12'(amp_reg - 12'sd1) : 12'(amp_reg);

    always_comb
    begin
        do_put = cmd.put_dc || cmd.put_ac || cmd.put_amp || cmd.put_pad;
        priority if (cmd.put_dc)
        begin
            put_entry = dc_rdata_reg;
        end
        else if (cmd.put_ac)
        begin
            put_entry = ac_rdata_reg;
        end
        else if (cmd.put_amp)
        begin
            put_entry = {1'b0, size_reg, 4'd0, amp_bits};
        end
        else
        begin
            put_entry = {5'd7, 9'd0, PAD_ONES};
        end
        put_len  = (put_entry[20:16] > 5'(MAX_CODE_LEN)) ? 5'(MAX_CODE_LEN) : put_entry[20:16];
        put_mask = (17'd1 << put_len) - 17'd1;
        put_code = put_entry[15:0] & put_mask[15:0];
    end

    assign drain_val = 8'(acc_reg >> (cnt_reg - 5'd8));

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (do_put)
        begin
            acc_next = (acc_reg << put_len) | ACC_W'(put_code);
            cnt_next = cnt_reg + put_len;
        end
        if (cmd.drain_byte)
        begin
            cnt_next = cnt_reg - 5'd8;
        end
        if (cmd.clear_pend)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zr_reg   <= '0;
            mcus_reg <= '0;
            rnum_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            zr_reg   <= zr_next;
            mcus_reg <= mcus_next;
            rnum_reg <= rnum_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    // byte emitter: one byte held back so the item's final byte carries last
    assign out_free = !out_valid_reg || !out_stall;
    assign emit_v   = cmd.drain_byte || cmd.emit_stuff || cmd.emit_ff || cmd.emit_rnum;

    always_comb
    begin
        priority if (cmd.drain_byte)
        begin
            emit_data = drain_val;
        end
        else if (cmd.emit_stuff)
        begin
            emit_data = BYTE_STUFF;
        end
        else if (cmd.emit_ff)
        begin
            emit_data = BYTE_FF;
        end
        else
        begin
            emit_data = MARKER_RST | {5'd0, rnum_reg};
        end
        held_v_next    = held_v_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit_v)
        begin
            held_v_next = 1'b1;
            if (held_v_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
        else if (cmd.flush)
        begin
            held_v_next    = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_v)
        begin
            held_reg <= emit_data;
            if (held_v_reg)
            begin
                out_byte_reg <= held_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (cmd.flush)
        begin
            out_byte_reg <= held_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_v_reg    <= held_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

    always_comb
    begin
        stat.kind        = kind_reg;
        stat.is_dc       = idx_reg == 6'd0;
        stat.val_zero    = val_reg == '0;
        stat.idx_last    = idx_reg == 6'(BLOCK_COEFS - 1);
        stat.restart_due = mstart_reg && restart_interval_reg != '0
                           && mcus_reg >= restart_interval_reg;
        stat.zr_gt15     = zr_reg > 6'd15;
        stat.count_ge8   = cnt_reg >= 5'd8;
        stat.byte_ff     = drain_val == BYTE_FF;
        stat.can_emit    = !held_v_reg || out_free;
        stat.held_v      = held_v_reg;
        stat.out_free    = out_free;
    end

endmodule

>>> hdl/jbhe_ctrl.sv
// Controller: sequences table lookups, code and amplitude puts, byte drain,
// stuffing, restart markers and the final flush. Uses jbhe_pkg.
module jbhe_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  jbhe_pkg::stat_t stat,
    output jbhe_pkg::cmd_t  cmd
);
    import jbhe_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_DECIDE   = 20'h00002,
        S_RST_PAD  = 20'h00004,
        S_RST_CLR  = 20'h00008,
        S_RST_FF   = 20'h00010,
        S_RST_NUM  = 20'h00020,
        S_DC_DIFF  = 20'h00040,
        S_DC_LOOK  = 20'h00080,
        S_DC_CODE  = 20'h00100,
        S_AMP      = 20'h00200,
        S_ZRL_CHK  = 20'h00400,
        S_ZRL_LOOK = 20'h00800,
        S_ZRL_CODE = 20'h01000,
        S_AC_LOOK  = 20'h02000,
        S_AC_CODE  = 20'h04000,
        S_EOB_LOOK = 20'h08000,
        S_EOB_CODE = 20'h10000,
        S_DRAIN    = 20'h20000,
        S_STUFF    = 20'h40000,
        S_FLUSH    = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t ret_reg;
    state_t ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.kind != KIND_COEF)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.is_dc)
                begin
                    state_next = stat.restart_due ? S_RST_PAD : S_DC_DIFF;
                end
                else
                begin
                    cmd.ac_prep = 1'b1;
                    if (stat.val_zero)
                    begin
                        cmd.zr_inc = 1'b1;
                        state_next = stat.idx_last ? S_EOB_LOOK : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ZRL_CHK;
                    end
                end
            end
            S_RST_PAD:
            begin
                cmd.put_pad = 1'b1;
                ret_next    = S_RST_CLR;
                state_next  = S_DRAIN;
            end
            S_RST_CLR:
            begin
                cmd.clear_pend = 1'b1;
                state_next     = S_RST_FF;
            end
            S_RST_FF:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_ff = 1'b1;
                    state_next  = S_RST_NUM;
                end
            end
            S_RST_NUM:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_rnum = 1'b1;
                    cmd.rst_apply = 1'b1;
                    state_next    = S_DC_DIFF;
                end
            end
            S_DC_DIFF:
            begin
                cmd.dc_diff = 1'b1;
                state_next  = S_DC_LOOK;
            end
            S_DC_LOOK:
            begin
                cmd.look_dc = 1'b1;
                state_next  = S_DC_CODE;
            end
            S_DC_CODE:
            begin
                cmd.put_dc = 1'b1;
                ret_next   = S_AMP;
                state_next = S_DRAIN;
            end
            S_AMP:
            begin
                cmd.put_amp  = 1'b1;
                cmd.zr_clear = 1'b1;
                ret_next     = S_FLUSH;
                state_next   = S_DRAIN;
            end
            S_ZRL_CHK:
            begin
                state_next = stat.zr_gt15 ? S_ZRL_LOOK : S_AC_LOOK;
            end
            S_ZRL_LOOK:
            begin
                cmd.look_zrl = 1'b1;
                state_next   = S_ZRL_CODE;
            end
            S_ZRL_CODE:
            begin
                cmd.put_ac   = 1'b1;
                cmd.zr_sub16 = 1'b1;
                ret_next     = S_ZRL_CHK;
                state_next   = S_DRAIN;
            end
            S_AC_LOOK:
            begin
                cmd.look_ac = 1'b1;
                state_next  = S_AC_CODE;
            end
            S_AC_CODE:
            begin
                cmd.put_ac = 1'b1;
                ret_next   = S_AMP;
                state_next = S_DRAIN;
            end
            S_EOB_LOOK:
            begin
                cmd.look_eob = 1'b1;
                state_next   = S_EOB_CODE;
            end
            S_EOB_CODE:
            begin
                cmd.put_ac   = 1'b1;
                cmd.zr_clear = 1'b1;
                ret_next     = S_FLUSH;
                state_next   = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.count_ge8)
                begin
                    state_next = ret_reg;
                end
                else if (stat.can_emit)
                begin
                    cmd.drain_byte = 1'b1;
                    state_next     = stat.byte_ff ? S_STUFF : S_DRAIN;
                end
            end
            S_STUFF:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_stuff = 1'b1;
                    state_next     = S_DRAIN;
                end
            end
            S_FLUSH:
            begin
                if (!stat.held_v)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

>>> hdl/jbhe_checker.sv
// Port-level checks for the entropy encoder top level, attached by bind.
// Depends on jbhe_pkg.
module jbhe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] kind,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last
);
    import jbhe_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    a_table_write_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind != KIND_COEF |=> in_stall ##1 !in_stall)
        else $error("table write did not finish in two cycles");

endmodule

bind jpeg_baseline_huffman_encoder_core jbhe_checker u_jbhe_checker (.*);
